// File: rtl/sfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfa_pkg;

    localparam int unsigned MIN_BLOCK = 48;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_HEAP  = 3'd2,
        ST_SMALL = 3'd3,
        ST_POOL  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD,
        S_NODE,
        S_UNLINK,
        S_SPARE,
        S_FILE,
        S_FPUSH1,
        S_FPUSH2,
        S_FHEAD,
        S_FWALK,
        S_FLINK1,
        S_FLINK2,
        S_HEAP,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        M_POP,
        M_WALK,
        M_SPLIT
    } mode_t;

endpackage
`default_nettype wire

// File: rtl/sfa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfa_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] request_bytes;
    logic [31:0] free_address;
    logic [31:0] free_block_size;

    modport source (output valid, kind, request_bytes, free_address, free_block_size,
                    input ready);
    modport sink (input valid, kind, request_bytes, free_address, free_block_size,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/sfa_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfa_res_if import sfa_pkg::*; ;
    logic        valid;
    logic        ready;
    logic [31:0] payload_address;
    logic [31:0] granted_size;
    status_t     status;

    modport source (output valid, payload_address, granted_size, status, input ready);
    modport sink (input valid, payload_address, granted_size, status, output ready);
endinterface
`default_nettype wire

// File: rtl/sfa_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfa_cfg_if import sfa_pkg::*; ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/sfa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module sfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/segregated_fit_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Segregated-fit block allocator. One request is handled at a time; the
// result waits in an output register, so the next request is taken while it
// is still unread. An allocate that pops a class head passes decode, head
// read, node read and unlink; heap growth goes from decode to the heap step,
// a rejected request from decode to the result. A split files the remainder
// after the unlink: into an empty class at once, into a non-empty class below
// the last by linking it before the head, then setting the old head's back
// link. A free takes a spare node and files the block the same way. Filing
// into the non-empty, size-sorted last class reads its head, walks the nodes
// by size, then links the new node and its neighbours; an allocate there
// walks them too, the node memories returning one node per cycle. A result
// that is still waiting holds the request in its final cycle. GRANULE_BYTES
// must be a power of two. No clearing pass runs after reset: the class heads
// are guarded by flip-flop flags and the spare node stack by a fill mark.
module segregated_fit_allocator_top
    import sfa_pkg::*;
#(
    parameter int NUM_CLASSES   = 64,
    parameter int GRANULE_BYTES = 4096,
    parameter int HEADER_BYTES  = 16,
    parameter int NODE_POOL     = 1024
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sfa_req_if.sink   req,
    sfa_res_if.source res,
    sfa_cfg_if.sink   cfg
);
    localparam int CW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int AW   = $clog2(NODE_POOL);
    localparam int NW   = $clog2(NODE_POOL + 1);
    localparam int GS   = $clog2(GRANULE_BYTES);
    localparam int LAST = NUM_CLASSES - 1;
    localparam logic [NW-1:0] NIL = NW'(NODE_POOL);

    function automatic logic [CW-1:0] clamp_class(input logic [33:0] v);
        logic [33:0] q;
        q = v >> GS;
        return (q > 34'(LAST)) ? CW'(LAST) : q[CW-1:0];
    endfunction

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic              kind_reg, kind_next;
    logic [31:0]       req_reg, req_next;
    logic [31:0]       faddr_reg, faddr_next;
    logic [31:0]       fsize_reg, fsize_next;
    logic [33:0]       total_reg, total_next;
    logic [CW-1:0]     cls_reg, cls_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [NW-1:0]     it_reg, it_next;
    logic [NW-1:0]     pre_reg, pre_next;
    logic [31:0]       naddr_reg, naddr_next;
    logic [31:0]       nsize_reg, nsize_next;
    logic [NW-1:0]     nnext_reg, nnext_next;
    logic [NW-1:0]     nprev_reg, nprev_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [NW-1:0]     min_reg, min_next;
    logic              useram_reg, useram_next;
    logic [31:0]       top_reg, top_next;
    logic [31:0]       used_reg, used_next;
    logic [31:0]       base_reg, base_next;
    logic [31:0]       limit_reg, limit_next;
    logic [NUM_CLASSES-1:0] ne_reg, ne_next;
    logic [31:0]       raddr_reg, raddr_next;
    logic [31:0]       rsize_reg, rsize_next;
    status_t           rstat_reg, rstat_next;
    logic              ovalid_reg, ovalid_next;
    logic [31:0]       oaddr_reg, oaddr_next;
    logic [31:0]       osize_reg, osize_next;
    status_t           ostat_reg, ostat_next;

    logic          head_we, head_re;
    logic [CW-1:0] head_wa, head_ra;
    logic [AW-1:0] head_wd, head_rd;
    logic          node_re;
    logic [AW-1:0] node_ra;
    logic          addr_we, size_we, next_we, prev_we;
    logic [AW-1:0] addr_wa, size_wa, next_wa, prev_wa;
    logic [31:0]   addr_wd, size_wd, addr_rd, size_rd;
    logic [NW-1:0] next_wd, prev_wd, next_rd, prev_rd;
    logic          spare_we, spare_re;
    logic [AW-1:0] spare_wa, spare_ra, spare_wd, spare_rd;

    logic [33:0]   round_c, total_c;
    logic          found_c;
    logic [CW-1:0] found_k;
    logic [31:0]   rest_c;
    logic [NW-1:0] cnt_dec;

    sfa_ram #(.WIDTH(AW), .DEPTH(NUM_CLASSES)) u_head (
        .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
        .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd)
    );
    sfa_ram #(.WIDTH(32), .DEPTH(NODE_POOL)) u_addr (
        .clk(clk), .wr_en(addr_we), .wr_addr(addr_wa), .wr_data(addr_wd),
        .rd_en(node_re), .rd_addr(node_ra), .rd_data(addr_rd)
    );
    sfa_ram #(.WIDTH(32), .DEPTH(NODE_POOL)) u_size (
        .clk(clk), .wr_en(size_we), .wr_addr(size_wa), .wr_data(size_wd),
        .rd_en(node_re), .rd_addr(node_ra), .rd_data(size_rd)
    );
    sfa_ram #(.WIDTH(NW), .DEPTH(NODE_POOL)) u_next (
        .clk(clk), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
        .rd_en(node_re), .rd_addr(node_ra), .rd_data(next_rd)
    );
    sfa_ram #(.WIDTH(NW), .DEPTH(NODE_POOL)) u_prev (
        .clk(clk), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
        .rd_en(node_re), .rd_addr(node_ra), .rd_data(prev_rd)
    );
    sfa_ram #(.WIDTH(AW), .DEPTH(NODE_POOL)) u_spare (
        .clk(clk), .wr_en(spare_we), .wr_addr(spare_wa), .wr_data(spare_wd),
        .rd_en(spare_re), .rd_addr(spare_ra), .rd_data(spare_rd)
    );

    assign req.ready           = (state_reg == S_IDLE);
    assign cfg.ready           = 1'b1;
    assign res.valid           = ovalid_reg;
    assign res.payload_address = oaddr_reg;
    assign res.granted_size    = osize_reg;
    assign res.status          = ostat_reg;

    always_comb
    begin
        round_c = (({2'b00, req.request_bytes} + 34'(2 * HEADER_BYTES)
                    + 34'(GRANULE_BYTES - 1)) >> GS) << GS;
        total_c = (round_c < 34'(MIN_BLOCK)) ? 34'(MIN_BLOCK) : round_c;
        rest_c  = nsize_reg - total_reg[31:0];
        cnt_dec = cnt_reg - NW'(1);
        found_c = 1'b0;
        found_k = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (ne_reg[i] && (CW'(i) > cls_reg))
            begin
                found_c = 1'b1;
                found_k = CW'(i);
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        kind_next   = kind_reg;
        req_next    = req_reg;
        faddr_next  = faddr_reg;
        fsize_next  = fsize_reg;
        total_next  = total_reg;
        cls_next    = cls_reg;
        cur_next    = cur_reg;
        it_next     = it_reg;
        pre_next    = pre_reg;
        naddr_next  = naddr_reg;
        nsize_next  = nsize_reg;
        nnext_next  = nnext_reg;
        nprev_next  = nprev_reg;
        cnt_next    = cnt_reg;
        min_next    = min_reg;
        useram_next = useram_reg;
        top_next    = top_reg;
        used_next   = used_reg;
        base_next   = base_reg;
        limit_next  = limit_reg;
        ne_next     = ne_reg;
        raddr_next  = raddr_reg;
        rsize_next  = rsize_reg;
        rstat_next  = rstat_reg;
        ovalid_next = ovalid_reg && !res.ready;
        oaddr_next  = oaddr_reg;
        osize_next  = osize_reg;
        ostat_next  = ostat_reg;

        head_we  = 1'b0;
        head_wa  = cls_reg;
        head_wd  = cur_reg[AW-1:0];
        head_re  = 1'b0;
        head_ra  = cls_reg;
        node_re  = 1'b0;
        node_ra  = cur_reg[AW-1:0];
        addr_we  = 1'b0;
        addr_wa  = cur_reg[AW-1:0];
        addr_wd  = faddr_reg;
        size_we  = 1'b0;
        size_wa  = cur_reg[AW-1:0];
        size_wd  = fsize_reg;
        next_we  = 1'b0;
        next_wa  = cur_reg[AW-1:0];
        next_wd  = NIL;
        prev_we  = 1'b0;
        prev_wa  = cur_reg[AW-1:0];
        prev_wd  = NIL;
        spare_we = 1'b0;
        spare_wa = cnt_reg[AW-1:0];
        spare_wd = cur_reg[AW-1:0];
        spare_re = 1'b0;
        spare_ra = cnt_dec[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    req_next   = req.request_bytes;
                    faddr_next = req.free_address;
                    fsize_next = req.free_block_size;
                    total_next = total_c;
                    cls_next   = (req.kind == KIND_FREE)
                                 ? clamp_class({2'b00, req.free_block_size})
                                 : clamp_class(total_c);
                    raddr_next = '0;
                    rsize_next = '0;
                    rstat_next = ST_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (req_reg == '0)
                    begin
                        rstat_next = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else if (total_reg[33:32] != 2'b00)
                    begin
                        rstat_next = ST_HEAP;
                        state_next = S_DONE;
                    end
                    else if (ne_reg[cls_reg])
                    begin
                        head_re    = 1'b1;
                        mode_next  = (cls_reg == CW'(LAST)) ? M_WALK : M_POP;
                        state_next = S_HEAD;
                    end
                    else if (found_c)
                    begin
                        head_re    = 1'b1;
                        head_ra    = found_k;
                        cls_next   = found_k;
                        mode_next  = M_SPLIT;
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_HEAP;
                    end
                end
                else
                begin
                    if (fsize_reg < 32'(MIN_BLOCK))
                    begin
                        rstat_next = ST_SMALL;
                        state_next = S_DONE;
                    end
                    else if (cnt_reg == '0)
                    begin
                        rstat_next = ST_POOL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        spare_re    = 1'b1;
                        useram_next = (cnt_dec >= min_reg);
                        cnt_next    = cnt_dec;
                        min_next    = (cnt_dec < min_reg) ? cnt_dec : min_reg;
                        state_next  = S_SPARE;
                    end
                end
            end
            S_HEAD:
            begin
                cur_next   = NW'(head_rd);
                node_re    = 1'b1;
                node_ra    = head_rd;
                state_next = S_NODE;
            end
            S_NODE:
            begin
                if ((mode_reg == M_WALK) && ({2'b00, size_rd} < total_reg))
                begin
                    if (next_rd == NIL)
                    begin
                        state_next = S_HEAP;
                    end
                    else
                    begin
                        cur_next = next_rd;
                        node_re  = 1'b1;
                        node_ra  = next_rd[AW-1:0];
                    end
                end
                else
                begin
                    naddr_next = addr_rd;
                    nsize_next = size_rd;
                    nnext_next = next_rd;
                    nprev_next = prev_rd;
                    state_next = S_UNLINK;
                end
            end
            S_UNLINK:
            begin
                if (nprev_reg == NIL)
                begin
                    head_we = 1'b1;
                    head_wd = nnext_reg[AW-1:0];
                    if (nnext_reg == NIL)
                    begin
                        ne_next[cls_reg] = 1'b0;
                    end
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = nprev_reg[AW-1:0];
                    next_wd = nnext_reg;
                end
                if (nnext_reg != NIL)
                begin
                    prev_we = 1'b1;
                    prev_wa = nnext_reg[AW-1:0];
                    prev_wd = nprev_reg;
                end
                raddr_next = naddr_reg;
                rstat_next = ST_OK;
                if ((mode_reg == M_SPLIT)
                    && ({2'b00, nsize_reg} >= total_reg + 34'(MIN_BLOCK)))
                begin
                    faddr_next = naddr_reg + total_reg[31:0];
                    fsize_next = rest_c;
                    cls_next   = clamp_class({2'b00, rest_c});
                    rsize_next = total_reg[31:0];
                    state_next = S_FILE;
                end
                else
                begin
                    spare_we   = 1'b1;
                    cnt_next   = cnt_reg + NW'(1);
                    if (mode_reg == M_SPLIT)
                    begin
                        rsize_next = nsize_reg;
                    end
                    else
                    begin
                        rsize_next = ({2'b00, nsize_reg} > total_reg)
                                     ? nsize_reg : total_reg[31:0];
                    end
                    state_next = S_DONE;
                end
            end
            S_SPARE:
            begin
                cur_next   = useram_reg ? NW'(spare_rd)
                                        : NW'(AW'(NODE_POOL - 1) - cnt_reg[AW-1:0]);
                state_next = S_FILE;
            end
            S_FILE:
            begin
                addr_we    = 1'b1;
                size_we    = 1'b1;
                rstat_next = ST_OK;
                if (ne_reg[cls_reg])
                begin
                    head_re    = 1'b1;
                    state_next = (cls_reg == CW'(LAST)) ? S_FHEAD : S_FPUSH1;
                end
                else
                begin
                    next_we          = 1'b1;
                    prev_we          = 1'b1;
                    head_we          = 1'b1;
                    ne_next[cls_reg] = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_FPUSH1:
            begin
                next_we    = 1'b1;
                next_wd    = NW'(head_rd);
                prev_we    = 1'b1;
                head_we    = 1'b1;
                it_next    = NW'(head_rd);
                state_next = S_FPUSH2;
            end
            S_FPUSH2:
            begin
                prev_we    = 1'b1;
                prev_wa    = it_reg[AW-1:0];
                prev_wd    = cur_reg;
                state_next = S_DONE;
            end
            S_FHEAD:
            begin
                it_next    = NW'(head_rd);
                pre_next   = NIL;
                node_re    = 1'b1;
                node_ra    = head_rd;
                state_next = S_FWALK;
            end
            S_FWALK:
            begin
                if (size_rd < fsize_reg)
                begin
                    pre_next = it_reg;
                    it_next  = next_rd;
                    if (next_rd == NIL)
                    begin
                        state_next = S_FLINK1;
                    end
                    else
                    begin
                        node_re = 1'b1;
                        node_ra = next_rd[AW-1:0];
                    end
                end
                else
                begin
                    state_next = S_FLINK1;
                end
            end
            S_FLINK1:
            begin
                next_we = 1'b1;
                next_wd = it_reg;
                prev_we = 1'b1;
                prev_wd = pre_reg;
                if (pre_reg == NIL)
                begin
                    head_we = 1'b1;
                end
                state_next = S_FLINK2;
            end
            S_FLINK2:
            begin
                if (it_reg != NIL)
                begin
                    prev_we = 1'b1;
                    prev_wa = it_reg[AW-1:0];
                    prev_wd = cur_reg;
                end
                if (pre_reg != NIL)
                begin
                    next_we = 1'b1;
                    next_wa = pre_reg[AW-1:0];
                    next_wd = cur_reg;
                end
                state_next = S_DONE;
            end
            S_HEAP:
            begin
                if (({2'b00, top_reg} + total_reg) > {2'b00, limit_reg})
                begin
                    rstat_next = ST_HEAP;
                end
                else
                begin
                    raddr_next = top_reg + 32'(HEADER_BYTES);
                    rsize_next = total_reg[31:0];
                    top_next   = top_reg + total_reg[31:0];
                    used_next  = used_reg + total_reg[31:0];
                    rstat_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || res.ready)
                begin
                    ovalid_next = 1'b1;
                    oaddr_next  = raddr_reg;
                    osize_next  = rsize_reg;
                    ostat_next  = rstat_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid)
        begin
            if (cfg.index == REG_HEAP_BASE)
            begin
                base_next = cfg.data;
                if (used_reg == '0)
                begin
                    top_next = cfg.data;
                end
            end
            else
            begin
                limit_next = cfg.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mode_reg   <= M_POP;
            kind_reg   <= KIND_ALLOC;
            req_reg    <= '0;
            faddr_reg  <= '0;
            fsize_reg  <= '0;
            total_reg  <= '0;
            cls_reg    <= '0;
            cur_reg    <= '0;
            it_reg     <= NIL;
            pre_reg    <= NIL;
            naddr_reg  <= '0;
            nsize_reg  <= '0;
            nnext_reg  <= NIL;
            nprev_reg  <= NIL;
            cnt_reg    <= NW'(NODE_POOL);
            min_reg    <= NW'(NODE_POOL);
            useram_reg <= 1'b0;
            top_reg    <= '0;
            used_reg   <= '0;
            base_reg   <= '0;
            limit_reg  <= '1;
            ne_reg     <= '0;
            raddr_reg  <= '0;
            rsize_reg  <= '0;
            rstat_reg  <= ST_OK;
            ovalid_reg <= 1'b0;
            oaddr_reg  <= '0;
            osize_reg  <= '0;
            ostat_reg  <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            kind_reg   <= kind_next;
            req_reg    <= req_next;
            faddr_reg  <= faddr_next;
            fsize_reg  <= fsize_next;
            total_reg  <= total_next;
            cls_reg    <= cls_next;
            cur_reg    <= cur_next;
            it_reg     <= it_next;
            pre_reg    <= pre_next;
            naddr_reg  <= naddr_next;
            nsize_reg  <= nsize_next;
            nnext_reg  <= nnext_next;
            nprev_reg  <= nprev_next;
            cnt_reg    <= cnt_next;
            min_reg    <= min_next;
            useram_reg <= useram_next;
            top_reg    <= top_next;
            used_reg   <= used_next;
            base_reg   <= base_next;
            limit_reg  <= limit_next;
            ne_reg     <= ne_next;
            raddr_reg  <= raddr_next;
            rsize_reg  <= rsize_next;
            rstat_reg  <= rstat_next;
            ovalid_reg <= ovalid_next;
            oaddr_reg  <= oaddr_next;
            osize_reg  <= osize_next;
            ostat_reg  <= ostat_next;
        end
    end
endmodule
`default_nettype wire

// File: tb/sfa_tb_if.sv
`timescale 1ns / 1ps
// The channel interfaces are provided by the RTL files sfa_req_if.sv,
// sfa_res_if.sv and sfa_cfg_if.sv; this file holds the shared test constants.
package sfa_tb_pkg;
    localparam int unsigned WATCHDOG_CYCLES = 200000;
endpackage

// File: tb/segregated_fit_allocator_top_tb.sv
`timescale 1ns / 1ps
module segregated_fit_allocator_top_tb;
    import sfa_pkg::*;
    import sfa_tb_pkg::*;

    localparam int NCLS = 64;
    localparam int GRAN = 4096;
    localparam int HDR = 16;
    localparam int POOL = 1024;
    localparam int NILN = POOL;

    typedef struct packed {
        logic [31:0] payload;
        logic [31:0] granted;
        status_t     status;
    } grant_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sfa_req_if req ();
    sfa_res_if res ();
    sfa_cfg_if cfg ();

    segregated_fit_allocator_top DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .res(res.source), .cfg(cfg.sink)
    );

    always #6 clk = ~clk;

    // Allocator mirror state.
    logic [31:0] base_reg, limit_reg, top_ptr, used_bytes;
    int          head_of[NCLS];
    bit          busy_cls[NCLS];
    logic [31:0] blk_addr[POOL], blk_size[POOL];
    int          nxt[POOL], prv[POOL];
    int          spare_stack[POOL];
    int          spare_cnt;

    grant_t      pending_grants[$];
    int          fails = 0;
    int          idle_cycles = 0;
    bit          hold_off = 1'b0;
    bit          stim_done = 1'b0;

    function automatic int size_class(logic [63:0] sz);
        logic [63:0] c;
        c = sz / GRAN;
        return (c > NCLS - 1) ? NCLS - 1 : int'(c);
    endfunction

    function automatic void mirror_reset();
        base_reg = 0;
        limit_reg = 32'hFFFF_FFFF;
        for (int i = 0; i < NCLS; i++)
        begin
            head_of[i] = NILN;
            busy_cls[i] = 0;
        end
        for (int i = 0; i < POOL; i++)
        begin
            spare_stack[i] = POOL - 1 - i;
            nxt[i] = NILN;
            prv[i] = NILN;
        end
        spare_cnt = POOL;
        top_ptr = 0;
        used_bytes = 0;
    endfunction

    function automatic void detach(int c, int n);
        int p;
        int x;
        p = prv[n];
        x = nxt[n];
        if (p == NILN)
        begin
            head_of[c] = x;
            if (x == NILN) busy_cls[c] = 0;
        end
        else
            nxt[p] = x;
        if (x != NILN) prv[x] = p;
        if (spare_cnt < POOL)
        begin
            spare_stack[spare_cnt] = n;
            spare_cnt++;
        end
    endfunction

    function automatic bit file_free_block(int c, logic [31:0] a, logic [31:0] s);
        int n;
        int it;
        int pre;
        if (spare_cnt == 0) return 0;
        spare_cnt--;
        n = spare_stack[spare_cnt] % POOL;
        blk_addr[n] = a;
        blk_size[n] = s;
        if (c == NCLS - 1 && busy_cls[c])
        begin
            it = head_of[c];
            pre = NILN;
            while (it != NILN && blk_size[it] < s)
            begin
                pre = it;
                it = nxt[it];
            end
            nxt[n] = it;
            prv[n] = pre;
            if (it != NILN) prv[it] = n;
            if (pre == NILN) head_of[c] = n; else nxt[pre] = n;
            return 1;
        end
        nxt[n] = busy_cls[c] ? head_of[c] : NILN;
        prv[n] = NILN;
        if (busy_cls[c]) prv[head_of[c]] = n;
        head_of[c] = n;
        busy_cls[c] = 1;
        return 1;
    endfunction

    function automatic grant_t predict_grant(logic k, logic [31:0] rq,
                                             logic [31:0] fa, logic [31:0] fs);
        grant_t g;
        logic [63:0] total;
        bit from_heap;
        int c;
        int n;
        int kk;
        logic [31:0] real_sz;
        g = '{payload: 0, granted: 0, status: ST_OK};
        from_heap = 0;
        if (k == KIND_ALLOC)
        begin
            total = ((64'(rq) + 2 * HDR + GRAN - 1) / GRAN) * GRAN;
            if (total < MIN_BLOCK) total = MIN_BLOCK;
            if (rq == 0)
                g.status = ST_ZERO;
            else if (total > 64'hFFFF_FFFF)
                g.status = ST_HEAP;
            else
            begin
                c = size_class(total);
                if (busy_cls[c])
                begin
                    n = head_of[c];
                    if (c == NCLS - 1)
                        while (n != NILN && 64'(blk_size[n]) < total) n = nxt[n];
                    if (n == NILN)
                        from_heap = 1;
                    else
                    begin
                        g.payload = blk_addr[n];
                        g.granted = (64'(blk_size[n]) > total) ? blk_size[n] : total[31:0];
                        detach(c, n);
                    end
                end
                else
                begin
                    for (kk = c + 1; kk < NCLS; kk++)
                        if (busy_cls[kk]) break;
                    if (kk >= NCLS)
                        from_heap = 1;
                    else
                    begin
                        n = head_of[kk];
                        g.payload = blk_addr[n];
                        real_sz = blk_size[n];
                        detach(kk, n);
                        if (64'(real_sz) >= total + MIN_BLOCK)
                        begin
                            void'(file_free_block(size_class(real_sz - total[31:0]),
                                                  g.payload + total[31:0],
                                                  real_sz - total[31:0]));
                            g.granted = total[31:0];
                        end
                        else
                            g.granted = real_sz;
                    end
                end
                if (from_heap)
                begin
                    if (64'(top_ptr) + total > 64'(limit_reg))
                        g.status = ST_HEAP;
                    else
                    begin
                        g.payload = top_ptr + HDR;
                        g.granted = total[31:0];
                        top_ptr = top_ptr + total[31:0];
                        used_bytes = used_bytes + total[31:0];
                    end
                end
            end
        end
        else
        begin
            if (fs < MIN_BLOCK)
                g.status = ST_SMALL;
            else if (!file_free_block(size_class(fs), fa, fs))
                g.status = ST_POOL;
        end
        return g;
    endfunction

    // Sender: one transfer per call, with bursty gaps.
    int burst_left = 0;

    task automatic send_request(logic k, logic [31:0] rq, logic [31:0] fa, logic [31:0] fs);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
        end
        burst_left--;
        req.valid <= 1'b1;
        req.kind <= k;
        req.request_bytes <= rq;
        req.free_address <= fa;
        req.free_block_size <= fs;
        do
            @(posedge clk);
        while (!req.ready);
        pending_grants.push_back(predict_grant(k, rq, fa, fs));
        @(negedge clk);
    endtask

    task automatic alloc_req(logic [31:0] rq);
        send_request(KIND_ALLOC, rq, $urandom, $urandom);
    endtask

    task automatic free_req(logic [31:0] a, logic [31:0] s);
        send_request(KIND_FREE, $urandom, a, s);
    endtask

    task automatic drain_results();
        req.valid <= 1'b0;
        while (pending_grants.size() != 0) @(negedge clk);
        repeat (3000) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == REG_HEAP_BASE)
        begin
            base_reg = val;
            if (used_bytes == 0) top_ptr = val;
        end
        else
            limit_reg = val;
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic test_directed();
        write_register(REG_HEAP_BASE, 32'h0001_0000);
        write_register(REG_HEAP_LIMIT, 32'h0100_0000);
        alloc_req(0);
        alloc_req(1);
        alloc_req(4064);
        alloc_req(4065);
        alloc_req(32'hFFFF_FFFF);
        alloc_req(32'hFFFF_FFE0);
        alloc_req(300000);
        free_req(32'h0000_0000, 47);
        free_req(32'hFFFF_FFF0, 48);
        free_req(32'h2000_0000, 4096);
        free_req(32'h3000_0000, 40960);
        alloc_req(100);
        alloc_req(100);
        free_req(32'h4000_0000, 32'h0010_0000);
        free_req(32'h5000_0000, 32'h0004_0000);
        free_req(32'h6000_0000, 32'hFFFF_FFFF);
        alloc_req(300000);
        alloc_req(250000);
        alloc_req(8000);
        alloc_req(32'h7000_0000);
        free_req(32'hFFFF_F000, 8192);
        alloc_req(8100);
        alloc_req(32'h0100_0000);
        drain_results();
    endtask

    task automatic test_heap_limits();
        write_register(REG_HEAP_LIMIT, 32'h0);
        alloc_req(10);
        alloc_req(32'hFFFF_FFFF);
        drain_results();
        write_register(REG_HEAP_BASE, 32'hFFFF_0000);
        write_register(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        repeat (20) alloc_req($urandom_range(1, 20000));
        drain_results();
    endtask

    task automatic test_pool_exhaust();
        for (int i = 0; i < 1040; i++)
            free_req($urandom, $urandom_range(48, 4095));
        drain_results();
    endtask

    task automatic test_random_mix();
        logic [31:0] sz;
        for (int i = 0; i < 800; i++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                case ($urandom_range(0, 5))
                    0: sz = $urandom;
                    1: sz = $urandom_range(0, 100);
                    default: sz = $urandom_range(1, 300000);
                endcase
                alloc_req(sz);
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: sz = $urandom;
                    1: sz = $urandom_range(0, 60);
                    default: sz = $urandom_range(48, 400000);
                endcase
                free_req($urandom, sz);
            end
            if (i == 400)
            begin
                drain_results();
                write_register(REG_HEAP_LIMIT, $urandom);
                write_register(REG_HEAP_BASE, $urandom);
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            repeat (30) alloc_req($urandom_range(1, 50000));
        join
        drain_results();
    endtask

    // Result receiver: stalls on its own pattern, checks each transfer.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                res.ready <= 1'b0;
            else
                case (($urandom_range(0, 63) >> 4))
                    0: res.ready <= 1'b0;
                    default: res.ready <= ($urandom_range(0, 3) != 0);
                endcase
        end
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fails++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (res.payload_address !== want.payload)
                begin
                    $error("payload_address exp %h got %h", want.payload, res.payload_address);
                    fails++;
                end
                if (res.granted_size !== want.granted)
                begin
                    $error("granted_size exp %h got %h", want.granted, res.granted_size);
                    fails++;
                end
                if (res.status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, res.status);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        req.valid = 1'b0;
        req.kind = KIND_ALLOC;
        req.request_bytes = 0;
        req.free_address = 0;
        req.free_block_size = 0;
        cfg.valid = 1'b0;
        cfg.index = REG_HEAP_BASE;
        cfg.data = 0;
        mirror_reset();
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_heap_limits();
        test_backpressure();
        test_pool_exhaust();
        test_random_mix();
        if (fails == 0 && pending_grants.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// File: files.f
rtl/sfa_pkg.sv
rtl/sfa_req_if.sv
rtl/sfa_res_if.sv
rtl/sfa_cfg_if.sv
rtl/sfa_ram.sv
rtl/segregated_fit_allocator_top.sv
tb/sfa_tb_if.sv
tb/segregated_fit_allocator_top_tb.sv
